### rtl/opi_pkg.sv
`default_nettype none
package opi_pkg;

    typedef struct packed {
        logic signed [15:0] lin_speed;
        logic signed [23:0] turn_rate;
        logic [19:0]        elapsed_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [23:0] corrected_rate;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_SUMS,
        ST_PROD,
        ST_ANGLE,
        ST_CORDIC,
        ST_ROUND,
        ST_MULX,
        ST_MULY,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic gain;
        logic sums;
        logic prod;
        logic angle;
        logic iter;
        logic round;
        logic mulx;
        logic muly;
        logic update;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic iter_last;
    } sts_t;

    localparam int AtanEntries = 24;
    localparam logic signed [33:0] CordicStart = 34'sd652032874;
    localparam logic [15:0] GainReset = 16'd18985;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2F9;
                5'd15: v = 32'h0000517C;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A2F;
                5'd19: v = 32'h00000517;
                5'd20: v = 32'h0000028B;
                5'd21: v = 32'h00000145;
                5'd22: v = 32'h000000A2;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/opi_ctrl.sv
`default_nettype none
module opi_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_fire,
    input  wire opi_pkg::sts_t sts,
    output opi_pkg::cmd_t      cmd,
    output logic               idle,
    output logic               busy_out
);

    opi_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= opi_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        busy_out = 1'b0;
        case (state_reg)
            opi_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                    state_next = opi_pkg::ST_GAIN;
            end
            opi_pkg::ST_GAIN:
            begin
                cmd.gain = 1'b1;
                state_next = opi_pkg::ST_SUMS;
            end
            opi_pkg::ST_SUMS:
            begin
                cmd.sums = 1'b1;
                state_next = opi_pkg::ST_PROD;
            end
            opi_pkg::ST_PROD:
            begin
                cmd.prod = 1'b1;
                state_next = opi_pkg::ST_ANGLE;
            end
            opi_pkg::ST_ANGLE:
            begin
                cmd.angle = 1'b1;
                state_next = opi_pkg::ST_CORDIC;
            end
            opi_pkg::ST_CORDIC:
            begin
                cmd.iter = 1'b1;
                if (sts.iter_last)
                    state_next = opi_pkg::ST_ROUND;
            end
            opi_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                state_next = opi_pkg::ST_MULX;
            end
            opi_pkg::ST_MULX:
            begin
                cmd.mulx = 1'b1;
                state_next = opi_pkg::ST_MULY;
            end
            opi_pkg::ST_MULY:
            begin
                cmd.muly = 1'b1;
                state_next = opi_pkg::ST_UPDATE;
            end
            opi_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = opi_pkg::ST_OUT;
            end
            opi_pkg::ST_OUT:
            begin
                busy_out = 1'b1;
                if (out_fire)
                    state_next = opi_pkg::ST_IDLE;
            end
            default:
                state_next = opi_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/opi_dp.sv
`default_nettype none
module opi_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire opi_pkg::cmd_t     cmd,
    input  wire opi_pkg::in_item_t in_data,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_data,
    output opi_pkg::sts_t          sts,
    output opi_pkg::out_item_t     out_data
);

    localparam int Steps = (CORDIC_STEPS < opi_pkg::AtanEntries) ?
                           CORDIC_STEPS : opi_pkg::AtanEntries;

    logic [15:0]        gain_reg;
    logic [31:0]        x_reg, y_reg, hd_reg;
    logic signed [15:0] pspeed_reg;
    logic signed [23:0] prate_reg;
    logic signed [15:0] speed_reg;
    logic signed [23:0] rate_reg;
    logic [19:0]        dt_reg;
    logic signed [23:0] corr_reg;
    logic signed [24:0] rsum_reg;
    logic signed [16:0] ssum_reg;
    logic signed [45:0] p_reg;
    logic signed [37:0] d_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic               flip_reg;
    logic [4:0]         iter_reg;
    logic signed [17:0] c16_reg, s16_reg;
    logic signed [31:0] dx_reg, dy_reg;

    // gain correction
    logic signed [40:0] gprod;
    logic signed [26:0] gq;
    logic signed [23:0] gsat;
    assign gprod = rate_reg * $signed({1'b0, gain_reg}) + 41'sd8192;
    assign gq = 27'(gprod >>> 14);
    always_comb
    begin
        if (gq > 27'sd8388607)
            gsat = 24'sh7FFFFF;
        else if (gq < -27'sd8388608)
            gsat = 24'sh800000;
        else
            gsat = gq[23:0];
    end

    // midpoint angle and fold
    logic [31:0]        pq, ph, mid;
    logic signed [32:0] zs;
    assign pq = 32'((p_reg + 46'sd2) >>> 2);
    assign ph = 32'((p_reg + 46'sd1) >>> 1);
    assign mid = hd_reg + pq;
    assign zs = 33'($signed(mid));

    // cordic step
    logic signed [33:0] shx, shy;
    logic signed [32:0] at;
    assign shx = cy_reg >>> iter_reg;
    assign shy = cx_reg >>> iter_reg;
    assign at = $signed({1'b0, opi_pkg::atan_lut(iter_reg)});
    assign sts.iter_last = (iter_reg == 5'(Steps - 1));

    // rounding and position multiply
    logic signed [33:0] fx, fy;
    logic signed [56:0] mx;
    assign fx = flip_reg ? -cx_reg : cx_reg;
    assign fy = flip_reg ? -cy_reg : cy_reg;
    assign mx = d_reg * (cmd.mulx ? c16_reg : s16_reg) + 57'sd67108864;

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= opi_pkg::GainReset;
            x_reg      <= '0;
            y_reg      <= '0;
            hd_reg     <= '0;
            pspeed_reg <= '0;
            prate_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                gain_reg <= cfg_data;
            if (cmd.update)
            begin
                x_reg      <= x_reg + dx_reg;
                y_reg      <= y_reg + dy_reg;
                hd_reg     <= hd_reg + ph;
                pspeed_reg <= speed_reg;
                prate_reg  <= corr_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            speed_reg <= in_data.lin_speed;
            rate_reg  <= in_data.turn_rate;
            dt_reg    <= in_data.elapsed_time;
        end
        if (cmd.gain)
            corr_reg <= gsat;
        if (cmd.sums)
        begin
            rsum_reg <= 25'(prate_reg) + 25'(corr_reg);
            ssum_reg <= 17'(pspeed_reg) + 17'(speed_reg);
        end
        if (cmd.prod)
        begin
            p_reg <= rsum_reg * $signed({1'b0, dt_reg});
            d_reg <= ssum_reg * $signed({1'b0, dt_reg});
        end
        if (cmd.angle)
        begin
            cx_reg   <= opi_pkg::CordicStart;
            cy_reg   <= '0;
            iter_reg <= '0;
            if (zs >= 33'sh040000000)
            begin
                cz_reg   <= zs - 33'sh080000000;
                flip_reg <= 1'b1;
            end
            else if (zs < -33'sh040000000)
            begin
                cz_reg   <= zs + 33'sh080000000;
                flip_reg <= 1'b1;
            end
            else
            begin
                cz_reg   <= zs;
                flip_reg <= 1'b0;
            end
        end
        if (cmd.iter)
        begin
            if (!cz_reg[32])
            begin
                cx_reg <= cx_reg - shx;
                cy_reg <= cy_reg + shy;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + shx;
                cy_reg <= cy_reg - shy;
                cz_reg <= cz_reg + at;
            end
            iter_reg <= iter_reg + 5'd1;
        end
        if (cmd.round)
        begin
            c16_reg <= 18'((fx + 34'sd8192) >>> 14);
            s16_reg <= 18'((fy + 34'sd8192) >>> 14);
        end
        if (cmd.mulx)
            dx_reg <= 32'(mx >>> 27);
        if (cmd.muly)
            dy_reg <= 32'(mx >>> 27);
    end

    assign out_data.pos_x = x_reg;
    assign out_data.pos_y = y_reg;
    assign out_data.heading = hd_reg[31:16];
    assign out_data.corrected_rate = prate_reg;

endmodule
`default_nettype wire

### rtl/odometry_pose_integrator.sv
// channel  | direction | signals
// request  | in        | in_valid, in_stall, in_data
// result   | out       | out_valid, out_stall, out_data
// config   | in        | cfg_we, cfg_data
// Result valid goes high once an accepted request has passed the gain, sums,
// product, angle, iterative CORDIC, round, multiply and update states.
// Only one request is in flight: in_stall stays high from acceptance until the
// result is taken.
// Reset clears pose, heading, previous speed and rate, gain to 18985.
// A stalled result holds; the next request waits until the result is taken.
`default_nettype none
module odometry_pose_integrator #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire opi_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output opi_pkg::out_item_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_data
);

    opi_pkg::cmd_t cmd;
    opi_pkg::sts_t sts;
    logic idle;

    // handshake
    assign in_stall = !idle;

    opi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && idle),
        .out_fire (out_valid && !out_stall),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle),
        .busy_out (out_valid)
    );

    opi_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

### rtl/opi_checker.sv
`default_nettype none
module opi_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire opi_pkg::out_item_t out_data
);

    // one request in flight at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while result pending");

    // accepted request gives no result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result too early");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // taken result frees the input
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !in_stall)
        else $error("input not freed");

endmodule

bind odometry_pose_integrator opi_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
